// ----- rtl/core/pal_pkg.sv -----
// Shared types and constants for the positional array list.
// Used by pal_cell, pal_ctrl and positional_array_list; no dependencies.
package pal_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the stream words
  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int DOUT_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;

  // Entry count holds 0..DEPTH; compares run at the wider of count and position
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [CMP_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] value;
  } pal_ctl_t;

endpackage

// ----- rtl/core/pal_cell.sv -----
// One storage cell of the list: holds a single entry and trades it with its
// neighbors on insert and delete. Depends on pal_pkg.
module pal_cell (
  input  logic                           clk,
  input  pal_pkg::pal_ctl_t              ctl,
  input  logic [pal_pkg::CMP_W-1:0]      idx,
  input  logic [pal_pkg::DATA_WIDTH-1:0] left,
  input  logic [pal_pkg::DATA_WIDTH-1:0] right,
  output logic [pal_pkg::DATA_WIDTH-1:0] word,
  output logic [pal_pkg::DATA_WIDTH-1:0] rd
);
  import pal_pkg::*;

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctl.ins) begin
      // open a gap at the position, take the lower neighbor above it
      if (idx > ctl.pos) begin
        word_next = left;
      end else if (idx == ctl.pos) begin
        word_next = ctl.value;
      end
    end else if (ctl.del) begin
      // close the gap, take the upper neighbor
      if (idx >= ctl.pos) begin
        word_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // drive onto the shared read bus only at the addressed cell
  assign rd = (idx == ctl.pos) ? word : '0;

endmodule

// ----- rtl/core/pal_ctrl.sv -----
// Command decode, entry count, status and the result word register.
// Depends on pal_pkg.
module pal_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [pal_pkg::CMD_W-1:0]      cmd,
  input  logic [pal_pkg::POS_W-1:0]      pos,
  input  logic [pal_pkg::VALUE_W-1:0]    value,
  input  logic [pal_pkg::DATA_WIDTH-1:0] rd_data,
  input  logic                           out_ready,
  output pal_pkg::pal_ctl_t              ctl,
  output logic                           out_valid,
  output logic [pal_pkg::DOUT_W-1:0]     data_out,
  output logic [pal_pkg::STAT_W-1:0]     status,
  output logic [pal_pkg::COUNT_W-1:0]    count_out,
  output logic                           empty_res,
  output logic                           full_res
);
  import pal_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_e_t        status_next;
  logic             keep_data;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             is_full;

  always_comb begin
    pos_x       = CMP_W'(pos);
    cnt_x       = CMP_W'(count);
    is_full     = (count == CNT_W'(DEPTH));
    status_next = ST_DONE;
    count_next  = count;
    keep_data   = 1'b0;
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    ctl.pos     = pos_x;
    ctl.value   = DATA_WIDTH'(value);
    unique case (cmd_e_t'(cmd))
      CMD_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_next = ST_BAD_POS;
        end else begin
          ctl.ins    = accept;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          // append is an insert just past the last entry
          ctl.ins    = accept;
          ctl.pos    = cnt_x;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status_next = ST_BAD_POS;
        end else begin
          keep_data = 1'b1;
          if (cmd_e_t'(cmd) == CMD_DELETE) begin
            ctl.del    = accept;
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        status_next = ST_BAD_POS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with the command
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out  <= keep_data ? DOUT_W'(rd_data) : '0;
      status    <= status_next;
      count_out <= COUNT_W'(count_next);
      empty_res <= (count_next == '0);
      full_res  <= (count_next == CNT_W'(DEPTH));
    end
  end

endmodule

// ----- rtl/core/positional_array_list.sv -----
// Top level of the positional array list: a row of storage cells and the
// command controller. Depends on pal_pkg, pal_cell and pal_ctrl.
//
// Holds an ordered list of up to DEPTH words and runs one command per input
// word: insert at a position, append, delete at a position or read at a
// position. Each command yields one result word in the cycle after it is
// accepted; a new command is taken whenever the result register is empty or
// its word is being taken in the same cycle, so the block sustains one
// command per cycle under a ready downstream. The rate is set by the row of
// cells: every cell loads from its left or right neighbor in the same cycle,
// so a shift of the whole list costs no more than a read, and a read gathers
// the addressed cell over an AND-OR bus across the row.
// Refused commands (bad position, full list) leave the list unchanged and
// report a status.
module positional_array_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [pal_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [pal_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] data_out, [39:32] count, [40] empty_res, [41] full_res, [47:42] zero
  output logic [pal_pkg::M_DATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic [pal_pkg::STAT_W-1:0]    m_tuser
);
  import pal_pkg::*;

  logic                  accept;
  pal_ctl_t              ctl;
  logic [DATA_WIDTH-1:0] words [DEPTH];
  logic [DATA_WIDTH-1:0] rds   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DOUT_W-1:0]     data_out;
  logic [COUNT_W-1:0]    count_out;
  logic                  empty_res;
  logic                  full_res;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (s_tuser),
    .pos       (s_tdata[POS_W-1:0]),
    .value     (s_tdata[POS_W+VALUE_W-1:POS_W]),
    .rd_data   (rd_data),
    .out_ready (m_tready),
    .ctl       (ctl),
    .out_valid (m_tvalid),
    .data_out  (data_out),
    .status    (m_tuser),
    .count_out (count_out),
    .empty_res (empty_res),
    .full_res  (full_res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = ctl.value;
    end else begin : g_mid_l
      assign left = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end

    pal_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (CMP_W'(i)),
      .left  (left),
      .right (right),
      .word  (words[i]),
      .rd    (rds[i])
    );
  end

  // only the addressed cell drives a nonzero word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rds[i];
    end
  end

  assign m_tdata = {6'd0, full_res, empty_res, count_out, data_out};

endmodule
